FILE: design/ipc_pkg.sv
// Package for the inverse Park / inverse Clarke transform.
// Field widths, CORDIC constants and the arctangent table; no dependencies.
`default_nettype none

package ipc_pkg;

	localparam int DW = 16;            // voltage field width, signed Q1.15
	localparam int AW = 16;            // angle width, 2^AW per turn
	localparam int KW = 16;            // inverse_scale width, unsigned Q2.14

	localparam int CS = 18;            // CORDIC iterations, one per stage
	localparam int CW = 33;            // CORDIC x/y width, Q1.30 plus guard
	localparam int ZW = 32;            // CORDIC angle accumulator width

	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic [17:0]          SQRT3_Q15   = 18'd56756;
	localparam logic [KW-1:0]        SCALE_RESET = 16'd16384;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic signed [ZW-1:0] ATAN_TURN32 [CS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215
	};

endpackage

`default_nettype wire

FILE: design/ipc_stream_if.sv
// Valid/ready channel interfaces for the transform: command and result beats.
// Depends on ipc_pkg for field widths.
`default_nettype none

interface ipc_cmd_if;
	logic                           valid;
	logic                           ready;
	logic signed [ipc_pkg::DW-1:0]  volt_d;
	logic signed [ipc_pkg::DW-1:0]  volt_q;
	logic        [ipc_pkg::AW-1:0]  angle;

	modport source (output valid, output volt_d, output volt_q, output angle, input ready);
	modport sink   (input valid, input volt_d, input volt_q, input angle, output ready);
endinterface

interface ipc_res_if;
	logic                           valid;
	logic                           ready;
	logic signed [ipc_pkg::DW-1:0]  volt_alpha;
	logic signed [ipc_pkg::DW-1:0]  volt_beta;
	logic signed [ipc_pkg::DW-1:0]  phase_a;
	logic signed [ipc_pkg::DW-1:0]  phase_b;
	logic signed [ipc_pkg::DW-1:0]  phase_c;

	modport source (output valid, output volt_alpha, output volt_beta, output phase_a,
		output phase_b, output phase_c, input ready);
	modport sink   (input valid, input volt_alpha, input volt_beta, input phase_a,
		input phase_b, input phase_c, output ready);
endinterface

`default_nettype wire

FILE: design/inverse_park_clarke_transform_top.sv
// Pipelined inverse Park + inverse Clarke transform with CORDIC sine/cosine.
// Depends on ipc_pkg and the channel interfaces in ipc_stream_if.sv.
//
//  channel   dir  handshake        payload
//  cmd       in   valid/ready      volt_d, volt_q, angle
//  res       out  valid/ready      volt_alpha, volt_beta, phase_a, phase_b, phase_c
//  cfg       in   cfg_we           cfg_wdata -> inverse_scale
//
// One beat per cycle while res.ready is high; 18 CORDIC stages, one quadrant/round
// stage, then multiply and round/saturate stages in turn.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// close up and a stalled result does not stop the front from filling.
// Reset clears the valid bits and loads inverse_scale with 1.0.
`default_nettype none

module inverse_park_clarke_transform_top (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [ipc_pkg::KW-1:0] cfg_wdata,
	ipc_cmd_if.sink                     cmd,
	ipc_res_if.source                   res
);
	import ipc_pkg::*;

	localparam int S_TRIG = CS + 1;    // rounded, quadrant-corrected sin/cos
	localparam int S_PARK = CS + 2;    // Park products
	localparam int S_AB   = CS + 3;    // alpha/beta
	localparam int S_SCL  = CS + 4;    // alpha*k, sqrt3*beta
	localparam int S_TBC  = CS + 5;    // phase_a, rounded b/c sums
	localparam int S_BCP  = CS + 6;    // b/c times k
	localparam int NST    = CS + 7;    // output stage
	localparam int WW     = 40;        // working width for round/saturate

	function automatic logic signed [WW-1:0] rnd(input logic signed [WW-1:0] v,
		input int n);
		logic signed [WW-1:0] half;
		half = WW'(1) <<< (n - 1);
		return (v + half) >>> n;
	endfunction

	function automatic logic signed [DW-1:0] sat(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] hi;
		logic signed [WW-1:0] lo;
		hi = (WW'(1) <<< (DW - 1)) - WW'(1);
		lo = -(WW'(1) <<< (DW - 1));
		if (v > hi) return hi[DW-1:0];
		else if (v < lo) return lo[DW-1:0];
		else return v[DW-1:0];
	endfunction

	function automatic logic signed [DW:0] clamp_unit(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] one;
		one = WW'(1) <<< (DW - 1);
		if (v > one) return one[DW:0];
		else if (v < -one) return -one[DW:0];
		else return v[DW:0];
	endfunction

	// configuration
	logic [KW-1:0] inverse_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			inverse_scale_q <= cfg_wdata;
		end
	end

	// valid bits and per-stage advance
	logic [NST:1]   vld_s;
	logic [NST+1:1] en;

	assign en[NST+1] = res.ready;
	assign cmd.ready = en[1];

	for (genvar k = 1; k <= NST; k++) begin : g_vld
		logic vin;
		if (k == 1) begin : g_first
			assign vin = cmd.valid;
		end else begin : g_rest
			assign vin = vld_s[k-1];
		end
		assign en[k] = !vld_s[k] || en[k+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= vin;
			end
		end
	end

	// CORDIC stages: stage g+1 holds the vector after iteration g
	logic signed [CW-1:0] cx_s [1:CS];
	logic signed [CW-1:0] cy_s [1:CS];
	logic signed [ZW-1:0] cz_s [1:CS];
	logic signed [DW-1:0] vd_s [1:CS];
	logic signed [DW-1:0] vq_s [1:CS];
	logic [1:0]           quad_s [1:CS];

	logic [31:0] angle32;
	assign angle32 = {cmd.angle, (32 - AW)'(0)};

	for (genvar g = 0; g < CS; g++) begin : g_cordic
		logic signed [CW-1:0] xi, yi, xs, ys;
		logic signed [ZW-1:0] zi;
		logic signed [DW-1:0] di, qi;
		logic [1:0]           ui;
		if (g == 0) begin : g_src_in
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = {2'b00, angle32[29:0]};
			assign di = cmd.volt_d;
			assign qi = cmd.volt_q;
			assign ui = angle32[31:30];
		end else begin : g_src_reg
			assign xi = cx_s[g];
			assign yi = cy_s[g];
			assign zi = cz_s[g];
			assign di = vd_s[g];
			assign qi = vq_s[g];
			assign ui = quad_s[g];
		end
		assign xs = xi >>> g;
		assign ys = yi >>> g;
		always_ff @(posedge clk) begin
			if (en[g+1]) begin
				if (!zi[ZW-1]) begin
					cx_s[g+1] <= xi - ys;
					cy_s[g+1] <= yi + xs;
					cz_s[g+1] <= zi - ATAN_TURN32[g];
				end else begin
					cx_s[g+1] <= xi + ys;
					cy_s[g+1] <= yi - xs;
					cz_s[g+1] <= zi + ATAN_TURN32[g];
				end
				vd_s[g+1]   <= di;
				vq_s[g+1]   <= qi;
				quad_s[g+1] <= ui;
			end
		end
	end

	// round to Q.15, clamp to +-1.0, then fold in the quadrant
	logic signed [DW:0]   cr, sr;
	logic signed [DW:0]   cos_s19, sin_s19;
	logic signed [DW-1:0] vd_s19, vq_s19;

	assign cr = clamp_unit(rnd(WW'(cx_s[CS]), 15));
	assign sr = clamp_unit(rnd(WW'(cy_s[CS]), 15));

	always_ff @(posedge clk) begin
		if (en[S_TRIG]) begin
			unique case (quad_s[CS])
				2'd0: begin
					cos_s19 <= cr;
					sin_s19 <= sr;
				end
				2'd1: begin
					cos_s19 <= -sr;
					sin_s19 <= cr;
				end
				2'd2: begin
					cos_s19 <= -cr;
					sin_s19 <= -sr;
				end
				default: begin
					cos_s19 <= sr;
					sin_s19 <= -cr;
				end
			endcase
			vd_s19 <= vd_s[CS];
			vq_s19 <= vq_s[CS];
		end
	end

	// inverse Park products
	logic signed [2*DW:0] cd_s20, sq_s20, sd_s20, cq_s20;

	always_ff @(posedge clk) begin
		if (en[S_PARK]) begin
			cd_s20 <= (2*DW+1)'(cos_s19) * (2*DW+1)'(vd_s19);
			sq_s20 <= (2*DW+1)'(sin_s19) * (2*DW+1)'(vq_s19);
			sd_s20 <= (2*DW+1)'(sin_s19) * (2*DW+1)'(vd_s19);
			cq_s20 <= (2*DW+1)'(cos_s19) * (2*DW+1)'(vq_s19);
		end
	end

	logic signed [DW-1:0] alpha_s21, beta_s21;

	always_ff @(posedge clk) begin
		if (en[S_AB]) begin
			alpha_s21 <= sat(rnd(WW'(cd_s20) - WW'(sq_s20), 15));
			beta_s21  <= sat(rnd(WW'(sd_s20) + WW'(cq_s20), 15));
		end
	end

	// scale alpha, weight beta by sqrt(3)
	logic signed [DW+KW:0]  ak_s22;
	logic signed [DW+17:0]  b3_s22;
	logic signed [DW-1:0]   alpha_s22, beta_s22;
	logic signed [KW:0]     kscale;

	assign kscale = {1'b0, inverse_scale_q};

	always_ff @(posedge clk) begin
		if (en[S_SCL]) begin
			ak_s22    <= (DW+KW+1)'(alpha_s21) * (DW+KW+1)'(kscale);
			b3_s22    <= (DW+18)'($signed(SQRT3_Q15)) * (DW+18)'(beta_s21);
			alpha_s22 <= alpha_s21;
			beta_s22  <= beta_s21;
		end
	end

	// b/c sums stay unsaturated; 18 bits hold the worst case
	logic signed [WW-1:0] am32;
	logic signed [WW-1:0] tb_w, tc_w;
	logic signed [17:0]   tb_s23, tc_s23;
	logic signed [DW-1:0] pa_s23, alpha_s23, beta_s23;

	assign am32 = -(WW'(alpha_s22) <<< 15);
	assign tb_w = rnd(am32 + WW'(b3_s22), 15);
	assign tc_w = rnd(am32 - WW'(b3_s22), 15);

	always_ff @(posedge clk) begin
		if (en[S_TBC]) begin
			pa_s23    <= sat(rnd(WW'(ak_s22), 14));
			tb_s23    <= tb_w[17:0];
			tc_s23    <= tc_w[17:0];
			alpha_s23 <= alpha_s22;
			beta_s23  <= beta_s22;
		end
	end

	logic signed [18+KW:0] bk_s24, ck_s24;
	logic signed [DW-1:0]  pa_s24, alpha_s24, beta_s24;

	always_ff @(posedge clk) begin
		if (en[S_BCP]) begin
			bk_s24    <= (19+KW)'(tb_s23) * (19+KW)'(kscale);
			ck_s24    <= (19+KW)'(tc_s23) * (19+KW)'(kscale);
			pa_s24    <= pa_s23;
			alpha_s24 <= alpha_s23;
			beta_s24  <= beta_s23;
		end
	end

	// output stage; shift by 15 folds in the divide by two
	logic signed [DW-1:0] alpha_s25, beta_s25, pa_s25, pb_s25, pc_s25;

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			alpha_s25 <= alpha_s24;
			beta_s25  <= beta_s24;
			pa_s25    <= pa_s24;
			pb_s25    <= sat(rnd(WW'(bk_s24), 15));
			pc_s25    <= sat(rnd(WW'(ck_s24), 15));
		end
	end

	assign res.valid      = vld_s[NST];
	assign res.volt_alpha = alpha_s25;
	assign res.volt_beta  = beta_s25;
	assign res.phase_a    = pa_s25;
	assign res.phase_b    = pb_s25;
	assign res.phase_c    = pc_s25;

	// an empty output stage means the whole ready chain is open
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[NST] |-> cmd.ready)
		else $error("cmd.ready low with empty output stage");

	// a result beat appears only by moving up from the stage before
	a_out_from_prev: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s[NST]) |-> $past(vld_s[NST-1]))
		else $error("output valid without a beat in the stage before");

	// sin/cos stay within +-1.0 after quadrant fold
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S_TRIG] |-> (cos_s19 <= 17'sd32768) && (cos_s19 >= -17'sd32768) &&
			(sin_s19 <= 17'sd32768) && (sin_s19 >= -17'sd32768))
		else $error("sin/cos out of unit range");

	// a held stage keeps its beat while blocked downstream
	a_hold_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S_AB] && !en[S_AB] |=> vld_s[S_AB] && $stable(alpha_s21) && $stable(beta_s21))
		else $error("blocked alpha/beta stage lost its beat");

endmodule

`default_nettype wire
